[sv/grt_pkg.sv]
package grt_pkg;

  localparam int POS_FRAC_BITS  = 16;
  localparam int RATE_FRAC_BITS = 8;

  localparam int POS_W    = 18;
  localparam int RATE_W   = 19;
  localparam int ALPHA_W  = 16;
  localparam int GAIN_W   = 10;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int ALPHA_SHIFT = 16;
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int RSH_R = (POS_FRAC_BITS >= RATE_FRAC_BITS) ?
                         (POS_FRAC_BITS - RATE_FRAC_BITS) : 0;
  localparam int RSH_L = (RATE_FRAC_BITS > POS_FRAC_BITS) ?
                         (RATE_FRAC_BITS - POS_FRAC_BITS) : 0;

  localparam logic signed [POS_W-1:0] POS_ONE  = POS_W'(64'sd1 <<< POS_FRAC_BITS);
  localparam logic signed [POS_W-1:0] CENTER_X = POS_W'((64'sd1 <<< POS_FRAC_BITS) / 4);
  localparam logic signed [POS_W-1:0] CENTER_Y =
    POS_W'(((64'sd1 <<< POS_FRAC_BITS) * 5 + 50) / 100);
  localparam logic signed [POS_W-1:0] SMX_RST = CENTER_X;
  localparam logic signed [POS_W-1:0] SMY_RST = CENTER_Y;

  localparam logic signed [PROD_W-1:0] CLAMP_X = PROD_W'(64'sd30 <<< RATE_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] CLAMP_Y = PROD_W'(-(64'sd25 <<< RATE_FRAC_BITS));
  localparam logic signed [PROD_W-1:0] RATE_MAX = PROD_W'(64'sd262143);
  localparam logic signed [PROD_W-1:0] RATE_MIN = PROD_W'(-64'sd262144);

  localparam logic KIND_RATE     = 1'b0;
  localparam logic KIND_RECENTER = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RST    = 16'd6554;
  localparam logic [GAIN_W-1:0]  GAIN_PX_RST  = 10'd80;
  localparam logic [GAIN_W-1:0]  GAIN_NX_RST  = 10'd100;
  localparam logic [GAIN_W-1:0]  GAIN_PY_RST  = 10'd200;
  localparam logic [GAIN_W-1:0]  GAIN_NY_RST  = 10'd150;
  localparam logic [ALPHA_W-1:0] DEADBAND_RST = 16'd3277;
  localparam logic [TICK_W-1:0]  STOP_RST     = 16'd1;
  localparam logic [TICK_W-1:0]  RECENTER_RST = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA       = 4'd0,
    CFG_GAIN_POS_X  = 4'd1,
    CFG_GAIN_NEG_X  = 4'd2,
    CFG_GAIN_POS_Y  = 4'd3,
    CFG_GAIN_NEG_Y  = 4'd4,
    CFG_DEADBAND_X  = 4'd5,
    CFG_STOP_TICKS  = 4'd6,
    CFG_RECENTER    = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SMX_A,
    OP_SMX_B,
    OP_SMY_A,
    OP_SMY_B,
    OP_RATE_X,
    OP_RATE_Y,
    OP_RATE_W
  } dp_op_e;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [GAIN_W-1:0]  gain_pos_x;
    logic [GAIN_W-1:0]  gain_neg_x;
    logic [GAIN_W-1:0]  gain_pos_y;
    logic [GAIN_W-1:0]  gain_neg_y;
    logic [ALPHA_W-1:0] deadband_x;
    logic [TICK_W-1:0]  stop_ticks;
    logic [TICK_W-1:0]  recenter_ticks;
  } cfg_t;

  typedef struct packed {
    logic   capture;
    logic   clear_idle;
    logic   tick_inc;
    logic   set_centered;
    dp_op_e op;
    logic   out_load;
    logic   out_kind;
    logic   out_use_rate;
    logic   out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic has_target;
    logic x_in_range;
    logic centered;
    logic stop_hit;
    logic rec_hit;
    logic out_free;
  } dp_status_t;

endpackage

[sv/grt_if.sv]
interface grt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic                                has_target;
  logic signed [grt_pkg::POS_W-1:0]    target_x;
  logic signed [grt_pkg::POS_W-1:0]    target_y;

  modport source(output valid, func, has_target, target_x, target_y, input ready);
  modport sink(input valid, func, has_target, target_x, target_y, output ready);
endinterface

interface grt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [grt_pkg::RATE_W-1:0]   rate_x;
  logic signed [grt_pkg::RATE_W-1:0]   rate_y;
  logic                                last;

  modport source(output valid, kind, rate_x, rate_y, last, input ready);
  modport sink(input valid, kind, rate_x, rate_y, last, output ready);
endinterface

interface grt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [grt_pkg::CFG_IDX_W-1:0]       index;
  logic [grt_pkg::CFG_DATA_W-1:0]      data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/gimbal_tracking_rate_controller.sv]
// Smoothed proportional pan/tilt tracker. A detection whose target x lies in
// range steps through SMX_A, SMX_B, SMY_A, SMY_B, RATE_X, RATE_Y and RATE_W,
// then waits in EMIT_RATE until the output register is free and loads its
// rate result; the next item is accepted in the cycle after that load. The
// four smoothing multiply-accumulate steps and the two gain products all
// share one 20x18 multiplier. A tick gives up to three results. Results wait
// in a single output register while the next item is accepted.
module gimbal_tracking_rate_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  grt_in_if.sink         in_ch_i,
  grt_out_if.source      out_ch_o,
  grt_cfg_if.sink        cfg_ch_i
);

  grt_pkg::cfg_t       cfg;
  grt_pkg::dp_cmd_t    cmd;
  grt_pkg::dp_status_t status;

  grt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_ch_i.valid),
    .wr_ready_o (cfg_ch_i.ready),
    .wr_index_i (cfg_ch_i.index),
    .wr_data_i  (cfg_ch_i.data),
    .cfg_o      (cfg)
  );

  grt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  grt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (in_ch_i.func),
    .has_target_i (in_ch_i.has_target),
    .target_x_i   (in_ch_i.target_x),
    .target_y_i   (in_ch_i.target_y),
    .out_valid_o  (out_ch_o.valid),
    .out_ready_i  (out_ch_o.ready),
    .out_kind_o   (out_ch_o.kind),
    .out_rate_x_o (out_ch_o.rate_x),
    .out_rate_y_o (out_ch_o.rate_y),
    .out_last_o   (out_ch_o.last)
  );

endmodule

[sv/grt_cfg_regs.sv]
module grt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_valid_i,
  output logic                            wr_ready_o,
  input  logic [grt_pkg::CFG_IDX_W-1:0]   wr_index_i,
  input  logic [grt_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output grt_pkg::cfg_t                   cfg_o
);

  grt_pkg::cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha          <= grt_pkg::ALPHA_RST;
      cfg_q.gain_pos_x     <= grt_pkg::GAIN_PX_RST;
      cfg_q.gain_neg_x     <= grt_pkg::GAIN_NX_RST;
      cfg_q.gain_pos_y     <= grt_pkg::GAIN_PY_RST;
      cfg_q.gain_neg_y     <= grt_pkg::GAIN_NY_RST;
      cfg_q.deadband_x     <= grt_pkg::DEADBAND_RST;
      cfg_q.stop_ticks     <= grt_pkg::STOP_RST;
      cfg_q.recenter_ticks <= grt_pkg::RECENTER_RST;
    end else if (wr_valid_i) begin
      unique case (grt_pkg::cfg_idx_e'(wr_index_i))
        grt_pkg::CFG_ALPHA:      cfg_q.alpha          <= wr_data_i[grt_pkg::ALPHA_W-1:0];
        grt_pkg::CFG_GAIN_POS_X: cfg_q.gain_pos_x     <= wr_data_i[grt_pkg::GAIN_W-1:0];
        grt_pkg::CFG_GAIN_NEG_X: cfg_q.gain_neg_x     <= wr_data_i[grt_pkg::GAIN_W-1:0];
        grt_pkg::CFG_GAIN_POS_Y: cfg_q.gain_pos_y     <= wr_data_i[grt_pkg::GAIN_W-1:0];
        grt_pkg::CFG_GAIN_NEG_Y: cfg_q.gain_neg_y     <= wr_data_i[grt_pkg::GAIN_W-1:0];
        grt_pkg::CFG_DEADBAND_X: cfg_q.deadband_x     <= wr_data_i[grt_pkg::ALPHA_W-1:0];
        grt_pkg::CFG_STOP_TICKS: cfg_q.stop_ticks     <= wr_data_i[grt_pkg::TICK_W-1:0];
        grt_pkg::CFG_RECENTER:   cfg_q.recenter_ticks <= wr_data_i[grt_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/grt_ctrl.sv]
module grt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  grt_pkg::dp_status_t  status_i,
  output grt_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMX_A,
    ST_SMX_B,
    ST_SMY_A,
    ST_SMY_B,
    ST_RATE_X,
    ST_RATE_Y,
    ST_RATE_W,
    ST_EMIT_RATE,
    ST_EMIT_STOP,
    ST_EMIT_REC,
    ST_EMIT_ZERO
  } state_e;

  state_e state_q, state_d;
  logic   rec_q, rec_d;

  always_comb begin
    state_d    = state_q;
    rec_d      = rec_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = grt_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!status_i.is_tick) begin
            if (status_i.has_target) begin
              cmd_o.clear_idle = 1'b1;
              if (status_i.x_in_range) begin
                state_d = ST_SMX_A;
              end
            end
          end else if (!status_i.centered) begin
            cmd_o.tick_inc     = 1'b1;
            cmd_o.set_centered = status_i.rec_hit;
            rec_d              = status_i.rec_hit;
            if (status_i.stop_hit) begin
              state_d = ST_EMIT_STOP;
            end else if (status_i.rec_hit) begin
              state_d = ST_EMIT_REC;
            end
          end
        end
      end
      ST_SMX_A: begin
        cmd_o.op = grt_pkg::OP_SMX_A;
        state_d  = ST_SMX_B;
      end
      ST_SMX_B: begin
        cmd_o.op = grt_pkg::OP_SMX_B;
        state_d  = ST_SMY_A;
      end
      ST_SMY_A: begin
        cmd_o.op = grt_pkg::OP_SMY_A;
        state_d  = ST_SMY_B;
      end
      ST_SMY_B: begin
        cmd_o.op = grt_pkg::OP_SMY_B;
        state_d  = ST_RATE_X;
      end
      ST_RATE_X: begin
        cmd_o.op = grt_pkg::OP_RATE_X;
        state_d  = ST_RATE_Y;
      end
      ST_RATE_Y: begin
        cmd_o.op = grt_pkg::OP_RATE_Y;
        state_d  = ST_RATE_W;
      end
      ST_RATE_W: begin
        cmd_o.op = grt_pkg::OP_RATE_W;
        state_d  = ST_EMIT_RATE;
      end
      ST_EMIT_RATE: begin
        if (status_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_kind     = grt_pkg::KIND_RATE;
          cmd_o.out_use_rate = 1'b1;
          cmd_o.out_last     = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_EMIT_STOP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = grt_pkg::KIND_RATE;
          cmd_o.out_last = !rec_q;
          state_d        = rec_q ? ST_EMIT_REC : ST_IDLE;
        end
      end
      ST_EMIT_REC: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = grt_pkg::KIND_RECENTER;
          state_d        = ST_EMIT_ZERO;
        end
      end
      ST_EMIT_ZERO: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = grt_pkg::KIND_RATE;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rec_q   <= rec_d;
    end
  end

`ifndef SYNTHESIS
  a_rec_then_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_REC && status_i.out_free) |=> (state_q == ST_EMIT_ZERO))
    else $error("recenter not followed by zero rate");
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load || cmd_o.op != grt_pkg::OP_NONE) |-> !in_ready_o)
    else $error("input taken while item in progress");
`endif

endmodule

[sv/grt_datapath.sv]
module grt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grt_pkg::cfg_t                       cfg_i,
  input  grt_pkg::dp_cmd_t                    cmd_i,
  output grt_pkg::dp_status_t                 status_o,
  input  logic                                func_i,
  input  logic                                has_target_i,
  input  logic signed [grt_pkg::POS_W-1:0]    target_x_i,
  input  logic signed [grt_pkg::POS_W-1:0]    target_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_kind_o,
  output logic signed [grt_pkg::RATE_W-1:0]   out_rate_x_o,
  output logic signed [grt_pkg::RATE_W-1:0]   out_rate_y_o,
  output logic                                out_last_o
);

  localparam int PW = grt_pkg::PROD_W;

  function automatic logic signed [grt_pkg::RATE_W-1:0] sat_rate(
    input logic signed [PW-1:0] v
  );
    logic signed [PW-1:0] r;
    r = v;
    if (r > grt_pkg::RATE_MAX) begin
      r = grt_pkg::RATE_MAX;
    end
    if (r < grt_pkg::RATE_MIN) begin
      r = grt_pkg::RATE_MIN;
    end
    return r[grt_pkg::RATE_W-1:0];
  endfunction

  logic signed [grt_pkg::POS_W-1:0]   x_q, y_q;
  logic signed [grt_pkg::POS_W-1:0]   sx_q, sy_q;
  logic [grt_pkg::TICK_W-1:0]         idle_q;
  logic                               centered_q;
  logic signed [PW-1:0]               acc_q, prod_q;
  logic signed [grt_pkg::RATE_W-1:0]  rx_q, ry_q;
  logic                               out_valid_q;
  logic                               out_kind_q, out_last_q;
  logic signed [grt_pkg::RATE_W-1:0]  out_rx_q, out_ry_q;

  logic [grt_pkg::TICK_W-1:0]         idle_inc;
  logic [grt_pkg::ALPHA_W:0]          one_m_alpha;
  logic signed [grt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [grt_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               prod;
  logic signed [PW-1:0]               mac;
  logic signed [grt_pkg::RATE_W-1:0]  dx, dy;
  logic signed [grt_pkg::MUL_A_W-1:0] dx_ext, neg_dy, dx_db;
  logic                               dx_pos, dx_neg, dy_neg;
  logic signed [PW-1:0]               rconv, rx_raw, ry_raw;
  logic                               out_free;

  assign idle_inc    = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign one_m_alpha = (grt_pkg::ALPHA_W+1)'(1 << grt_pkg::ALPHA_SHIFT)
                       - {1'b0, cfg_i.alpha};
  assign out_free    = !out_valid_q || out_ready_i;

  assign status_o.is_tick    = func_i;
  assign status_o.has_target = has_target_i;
  assign status_o.x_in_range = !target_x_i[grt_pkg::POS_W-1] &&
                               (target_x_i <= grt_pkg::POS_ONE);
  assign status_o.centered   = centered_q;
  assign status_o.stop_hit   = idle_inc > cfg_i.stop_ticks;
  assign status_o.rec_hit    = idle_inc > cfg_i.recenter_ticks;
  assign status_o.out_free   = out_free;

  assign dx     = {sx_q[grt_pkg::POS_W-1], sx_q} - grt_pkg::RATE_W'(grt_pkg::CENTER_X);
  assign dy     = {sy_q[grt_pkg::POS_W-1], sy_q} - grt_pkg::RATE_W'(grt_pkg::CENTER_Y);
  assign dx_ext = {dx[grt_pkg::RATE_W-1], dx};
  assign neg_dy = -{dy[grt_pkg::RATE_W-1], dy};
  assign dx_db  = dx_ext + grt_pkg::MUL_A_W'(cfg_i.deadband_x);
  assign dx_pos = !dx[grt_pkg::RATE_W-1] && (dx != '0);
  assign dx_neg = dx_db[grt_pkg::MUL_A_W-1];
  assign dy_neg = dy[grt_pkg::RATE_W-1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      grt_pkg::OP_SMX_A: begin
        mul_a = grt_pkg::MUL_A_W'(cfg_i.alpha);
        mul_b = x_q;
      end
      grt_pkg::OP_SMX_B: begin
        mul_a = grt_pkg::MUL_A_W'(one_m_alpha);
        mul_b = sx_q;
      end
      grt_pkg::OP_SMY_A: begin
        mul_a = grt_pkg::MUL_A_W'(cfg_i.alpha);
        mul_b = y_q;
      end
      grt_pkg::OP_SMY_B: begin
        mul_a = grt_pkg::MUL_A_W'(one_m_alpha);
        mul_b = sy_q;
      end
      grt_pkg::OP_RATE_X: begin
        mul_a = dx_ext;
        mul_b = grt_pkg::MUL_B_W'(dx_pos ? cfg_i.gain_pos_x : cfg_i.gain_neg_x);
      end
      grt_pkg::OP_RATE_Y: begin
        mul_a = neg_dy;
        mul_b = grt_pkg::MUL_B_W'(dy_neg ? cfg_i.gain_pos_y : cfg_i.gain_neg_y);
      end
      grt_pkg::OP_NONE, grt_pkg::OP_RATE_W: ;
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign mac   = acc_q + prod;
  assign rconv = (prod_q >>> grt_pkg::RSH_R) <<< grt_pkg::RSH_L;

  always_comb begin
    rx_raw = '0;
    if (dx_pos) begin
      rx_raw = (rconv > grt_pkg::CLAMP_X) ? grt_pkg::CLAMP_X : rconv;
    end else if (dx_neg) begin
      rx_raw = rconv;
    end
    ry_raw = rconv;
    if (!dy_neg && (rconv < grt_pkg::CLAMP_Y)) begin
      ry_raw = grt_pkg::CLAMP_Y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q        <= grt_pkg::SMX_RST;
      sy_q        <= grt_pkg::SMY_RST;
      idle_q      <= '0;
      centered_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_idle) begin
        idle_q     <= '0;
        centered_q <= 1'b0;
      end else if (cmd_i.tick_inc) begin
        idle_q <= idle_inc;
        if (cmd_i.set_centered) begin
          centered_q <= 1'b1;
        end
      end
      if (cmd_i.op == grt_pkg::OP_SMX_B) begin
        sx_q <= mac[grt_pkg::ALPHA_SHIFT +: grt_pkg::POS_W];
      end
      if (cmd_i.op == grt_pkg::OP_SMY_B) begin
        sy_q <= mac[grt_pkg::ALPHA_SHIFT +: grt_pkg::POS_W];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= target_x_i;
      y_q <= target_y_i;
    end
    if (cmd_i.op == grt_pkg::OP_SMX_A || cmd_i.op == grt_pkg::OP_SMY_A) begin
      acc_q <= prod;
    end
    if (cmd_i.op == grt_pkg::OP_RATE_X || cmd_i.op == grt_pkg::OP_RATE_Y) begin
      prod_q <= prod;
    end
    if (cmd_i.op == grt_pkg::OP_RATE_Y) begin
      rx_q <= sat_rate(rx_raw);
    end
    if (cmd_i.op == grt_pkg::OP_RATE_W) begin
      ry_q <= sat_rate(ry_raw);
    end
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_last_q <= cmd_i.out_last;
      out_rx_q   <= cmd_i.out_use_rate ? rx_q : '0;
      out_ry_q   <= cmd_i.out_use_rate ? ry_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_rate_x_o = out_rx_q;
  assign out_rate_y_o = out_ry_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("pending result overwritten");
  a_recenter_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.out_kind == grt_pkg::KIND_RECENTER)
      |-> (!cmd_i.out_last && !cmd_i.out_use_rate))
    else $error("bad recenter result");
  a_mac_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == grt_pkg::OP_SMX_B) |-> ($past(cmd_i.op) == grt_pkg::OP_SMX_A))
    else $error("smoothing step out of order");
`endif

endmodule
